### hw/rtl/bba_pkg.sv
// shared types, constants and bit helpers of the bitmap block allocator
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

  localparam int NUM_BITS_DEF = 4096;

  localparam int OPC_W  = 3;
  localparam int BIT_W  = 12;
  localparam int BYTE_W = 9;
  localparam int VAL_W  = 8;
  localparam int CNT_W  = 13;

  typedef enum logic [OPC_W-1:0] {
    OP_LOAD   = 3'd0,
    OP_RESCAN = 3'd1,
    OP_READ   = 3'd2,
    OP_SET    = 3'd3,
    OP_CLEAR  = 3'd4,
    OP_ALLOC  = 3'd5
  } op_t;

  typedef struct packed {
    logic accept;
    logic commit;
    logic scan_start;
    logic out_load;
    logic out_direct;
  } bba_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_end;
  } bba_stat_t;

  function automatic logic [3:0] zeros_in(input logic [7:0] b);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      if (!b[i]) n = n + 4'd1;
    end
    return n;
  endfunction

  function automatic logic [2:0] lowest_zero(input logic [7:0] b);
    logic [2:0] k;
    logic       hit;
    k   = '0;
    hit = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!b[i] && !hit) begin
        k   = 3'(i);
        hit = 1'b1;
      end
    end
    return k;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/bba_if.sv
// request and result channel interfaces of the bitmap block allocator
`timescale 1ns / 1ps
`default_nettype none

interface bba_in_if import bba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OPC_W-1:0]  opcode;
  logic [BIT_W-1:0]  bit_index;
  logic [BYTE_W-1:0] byte_index;
  logic [VAL_W-1:0]  load_value;
  logic              write_back;

  modport source (output valid, opcode, bit_index, byte_index, load_value, write_back,
                  input ready);
  modport sink (input valid, opcode, bit_index, byte_index, load_value, write_back,
                output ready);
endinterface

interface bba_out_if import bba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              bit_value;
  logic [BIT_W-1:0]  alloc_index;
  logic              alloc_ok;
  logic [BIT_W-1:0]  first_free_index;
  logic              first_free_valid;
  logic [CNT_W-1:0]  free_count;
  logic              dump_valid;
  logic [BYTE_W-1:0] dump_byte_index;
  logic [VAL_W-1:0]  dump_byte_value;

  modport source (output valid, bit_value, alloc_index, alloc_ok, first_free_index,
                  first_free_valid, free_count, dump_valid, dump_byte_index,
                  dump_byte_value, input ready);
  modport sink (input valid, bit_value, alloc_index, alloc_ok, first_free_index,
                first_free_valid, free_count, dump_valid, dump_byte_index,
                dump_byte_value, output ready);
endinterface

`default_nettype wire

### hw/rtl/bba_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### hw/rtl/bba_ctrl.sv
// sequencing state machine and handshakes of the bitmap block allocator
`timescale 1ns / 1ps
`default_nettype none

module bba_ctrl import bba_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  bba_stat_t st,
  output bba_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // search or rescan runs before the result; otherwise hold until the slot frees
        if (st.need_scan) begin
          cmd.commit     = 1'b1;
          cmd.scan_start = 1'b1;
          state_nxt      = ST_SCAN;
        end else if (out_free) begin
          cmd.commit     = 1'b1;
          cmd.out_load   = 1'b1;
          cmd.out_direct = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (st.scan_end) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register loaded while a result still waits");

  a_scan_end_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    st.scan_end |-> (state_r == ST_SCAN))
    else $error("scan finished outside the scan state");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (state_r == ST_EXEC))
    else $error("accepted transfer not followed by execute");

endmodule

`default_nettype wire

### hw/rtl/bba_dp.sv
// bitmap store, first-free and count registers, byte scan engine and result register
`timescale 1ns / 1ps
`default_nettype none

module bba_dp import bba_pkg::*; #(
  parameter int NUM_BITS = NUM_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bba_cmd_t          cmd,
  output bba_stat_t         st,
  input  logic [OPC_W-1:0]  in_opcode,
  input  logic [BIT_W-1:0]  in_bit_index,
  input  logic [BYTE_W-1:0] in_byte_index,
  input  logic [VAL_W-1:0]  in_load_value,
  input  logic              in_write_back,
  output logic              out_bit_value,
  output logic [BIT_W-1:0]  out_alloc_index,
  output logic              out_alloc_ok,
  output logic [BIT_W-1:0]  out_first_free_index,
  output logic              out_first_free_valid,
  output logic [CNT_W-1:0]  out_free_count,
  output logic              out_dump_valid,
  output logic [BYTE_W-1:0] out_dump_byte_index,
  output logic [VAL_W-1:0]  out_dump_byte_value
);

  localparam int NBYTES = NUM_BITS / 8;
  localparam int AW     = (NBYTES > 1) ? $clog2(NBYTES) : 1;
  localparam int BIW    = AW + 3;
  localparam int NVALID = NBYTES * 8;
  localparam int FCW    = $clog2(NVALID + 1);
  localparam logic [AW:0]    SCAN_END = (AW + 1)'(NBYTES);
  localparam logic [FCW-1:0] FB_MAX   = FCW'(NVALID);

  // latched request
  logic [OPC_W-1:0]  op_r;
  logic [BIT_W-1:0]  bit_r;
  logic [BYTE_W-1:0] byte_r;
  logic [VAL_W-1:0]  val_r;
  logic              wb_r;

  // allocator state
  logic [BIT_W-1:0] unused_bits;
  logic [BIW-1:0]   ff_r, ff_nxt;
  logic             ok_r, ok_nxt;
  logic [FCW-1:0]   fb_r, fb_nxt;

  // scan engine
  logic          busy_r, busy_nxt;
  logic          cnt_mode_r, cnt_mode_nxt;
  logic [AW:0]   rd_cnt_r, rd_cnt_nxt;
  logic          dat_vld_r, dat_vld_nxt;
  logic [AW-1:0] dat_addr_r, dat_addr_nxt;
  logic          issue, found_now, scan_end;

  // ram port
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  // execute step
  logic           is_alloc, is_set, is_clr, is_used, is_load, is_rescan;
  logic           bit_rng, byte_rng, do_change, need_search;
  logic [BIW-1:0] tb;
  logic [AW-1:0]  pos;
  logic [7:0]     mask, old_b, new_b;

  logic              r_bit, r_aok, r_dv;
  logic [BIT_W-1:0]  r_aidx;
  logic [BYTE_W-1:0] r_didx;
  logic [VAL_W-1:0]  r_dval;

  // staged results for operations that finish after a scan
  logic              s_bit_r, s_aok_r, s_dv_r;
  logic [BIT_W-1:0]  s_aidx_r;
  logic [BYTE_W-1:0] s_didx_r;
  logic [VAL_W-1:0]  s_dval_r;

  // result register
  logic              o_bit_r, o_aok_r, o_ffv_r, o_dv_r;
  logic [BIT_W-1:0]  o_aidx_r, o_ffi_r;
  logic [CNT_W-1:0]  o_cnt_r;
  logic [BYTE_W-1:0] o_didx_r;
  logic [VAL_W-1:0]  o_dval_r;

  bba_ram #(
    .WIDTH (8),
    .DEPTH (NBYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= in_opcode;
      bit_r  <= in_bit_index;
      byte_r <= in_byte_index;
      val_r  <= in_load_value;
      wb_r   <= in_write_back;
    end
  end

  always_comb begin
    is_alloc  = (op_r == OP_ALLOC);
    is_set    = (op_r == OP_SET);
    is_clr    = (op_r == OP_CLEAR);
    is_load   = (op_r == OP_LOAD);
    is_rescan = (op_r == OP_RESCAN);
    is_used   = is_set || is_alloc;
    bit_rng   = 32'(bit_r) < 32'(NVALID);
    byte_rng  = 32'(byte_r) < 32'(NBYTES);
    tb        = is_alloc ? ff_r : BIW'(bit_r);
    pos       = tb[BIW-1:3];
    mask      = 8'b1 << tb[2:0];
    old_b     = ram_rdata;
    new_b     = is_used ? (old_b | mask) : (old_b & ~mask);
    do_change = ((is_set || is_clr) && bit_rng) || (is_alloc && ok_r);
    // marking the first free bit used restarts the search at its byte
    need_search = do_change && is_used && ok_r && (tb == ff_r);

    r_bit  = (op_r == OP_READ) && bit_rng && old_b[bit_r[2:0]];
    r_aok  = is_alloc && ok_r;
    r_aidx = r_aok ? BIT_W'(ff_r) : '0;
    r_dv   = do_change && (is_alloc || wb_r);
    r_didx = r_dv ? BYTE_W'(pos) : '0;
    r_dval = r_dv ? new_b : '0;
  end

  assign st.need_scan = is_rescan || need_search;

  assign issue     = (rd_cnt_r != SCAN_END);
  assign found_now = dat_vld_r && (ram_rdata != 8'hFF) && !ok_r;
  assign scan_end  = busy_r && ((!dat_vld_r && !issue) || (!cnt_mode_r && found_now));
  assign st.scan_end = scan_end;

  always_comb begin
    ff_nxt       = ff_r;
    ok_nxt       = ok_r;
    fb_nxt       = fb_r;
    busy_nxt     = busy_r;
    cnt_mode_nxt = cnt_mode_r;
    rd_cnt_nxt   = rd_cnt_r;
    dat_vld_nxt  = dat_vld_r;
    dat_addr_nxt = dat_addr_r;

    if (cmd.commit) begin
      if (do_change && (new_b != old_b)) begin
        if (is_used) begin
          if (fb_r != '0) fb_nxt = fb_r - FCW'(1);
        end else if (fb_r < FB_MAX) begin
          fb_nxt = fb_r + FCW'(1);
        end
      end
      if (do_change && is_clr && (!ok_r || (tb < ff_r))) begin
        ff_nxt = tb;
        ok_nxt = 1'b1;
      end
    end

    if (cmd.scan_start) begin
      ff_nxt       = '0;
      ok_nxt       = 1'b0;
      if (is_rescan) fb_nxt = '0;
      busy_nxt     = 1'b1;
      cnt_mode_nxt = is_rescan;
      rd_cnt_nxt   = is_rescan ? '0 : {1'b0, pos};
      dat_vld_nxt  = 1'b0;
    end

    if (busy_r) begin
      if (issue) rd_cnt_nxt = rd_cnt_r + (AW + 1)'(1);
      dat_vld_nxt  = issue;
      dat_addr_nxt = rd_cnt_r[AW-1:0];
      if (dat_vld_r) begin
        if (cnt_mode_r) fb_nxt = fb_r + FCW'(zeros_in(ram_rdata));
        if (found_now) begin
          ff_nxt = {dat_addr_r, lowest_zero(ram_rdata)};
          ok_nxt = 1'b1;
        end
      end
      if (scan_end) busy_nxt = 1'b0;
    end
  end

  always_comb begin
    ram_we    = cmd.commit && (do_change || (is_load && byte_rng));
    ram_waddr = is_load ? AW'(byte_r) : pos;
    ram_wdata = is_load ? val_r : new_b;
    ram_re    = cmd.accept || (busy_r && issue);
    if (busy_r) begin
      ram_raddr = rd_cnt_r[AW-1:0];
    end else if (in_opcode == OP_ALLOC) begin
      ram_raddr = ff_r[BIW-1:3];
    end else begin
      ram_raddr = AW'(in_bit_index >> 3);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ff_r      <= '0;
      ok_r      <= 1'b0;
      fb_r      <= '0;
      busy_r    <= 1'b0;
      dat_vld_r <= 1'b0;
    end else begin
      ff_r      <= ff_nxt;
      ok_r      <= ok_nxt;
      fb_r      <= fb_nxt;
      busy_r    <= busy_nxt;
      dat_vld_r <= dat_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_mode_r <= cnt_mode_nxt;
    rd_cnt_r   <= rd_cnt_nxt;
    dat_addr_r <= dat_addr_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      s_bit_r  <= r_bit;
      s_aok_r  <= r_aok;
      s_aidx_r <= r_aidx;
      s_dv_r   <= r_dv;
      s_didx_r <= r_didx;
      s_dval_r <= r_dval;
    end
  end

  assign unused_bits = ok_nxt ? BIT_W'(ff_nxt) : '0;

  // status fields always show the state after this transfer
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_bit_r  <= cmd.out_direct ? r_bit  : s_bit_r;
      o_aok_r  <= cmd.out_direct ? r_aok  : s_aok_r;
      o_aidx_r <= cmd.out_direct ? r_aidx : s_aidx_r;
      o_dv_r   <= cmd.out_direct ? r_dv   : s_dv_r;
      o_didx_r <= cmd.out_direct ? r_didx : s_didx_r;
      o_dval_r <= cmd.out_direct ? r_dval : s_dval_r;
      o_ffi_r  <= unused_bits;
      o_ffv_r  <= ok_nxt;
      o_cnt_r  <= CNT_W'(fb_nxt);
    end
  end

  assign out_bit_value        = o_bit_r;
  assign out_alloc_index      = o_aidx_r;
  assign out_alloc_ok         = o_aok_r;
  assign out_first_free_index = o_ffi_r;
  assign out_first_free_valid = o_ffv_r;
  assign out_free_count       = o_cnt_r;
  assign out_dump_valid       = o_dv_r;
  assign out_dump_byte_index  = o_didx_r;
  assign out_dump_byte_value  = o_dval_r;

  a_scan_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_start |=> busy_r)
    else $error("scan engine did not start");

  a_commit_idle_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit || cmd.accept) |-> !busy_r)
    else $error("ram port used by a transfer while scanning");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fb_r <= FB_MAX)
    else $error("free count above the number of bits");

endmodule

`default_nettype wire

### hw/rtl/bitmap_block_allocator.sv
// Free-space bitmap allocator, first fit; a set bit marks a used block.
//
// in_chan carries one operation per transfer: load byte, rescan, read bit,
// mark used, mark free or allocate. out_chan returns exactly one result per
// operation, in order, with the first free index, its valid flag and the free
// count after the operation, plus the changed byte for write-back.
// Load, read, mark used, mark free and allocate run as an accept step, then one
// ram read-modify-write. When mark used or allocate takes the first free bit, a
// byte walk from that byte follows, one byte per cycle through the single ram
// read port, until a byte with a free bit or the end of the map. Rescan walks
// every byte. A new operation is taken while a finished result waits on
// out_chan; if out_chan stays stalled, the next operation holds in its execute
// or done step and in_chan is not ready until that result can be placed.
// Reset clears the first free index, its flag, the free count and both
// channel controls; bitmap contents are undefined until loaded, so every
// byte must be loaded before a rescan. No clearing pass is run.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_block_allocator import bba_pkg::*; #(
  parameter int NUM_BITS = NUM_BITS_DEF
) (
  input logic     clk,
  input logic     rst_n,
  bba_in_if.sink  in_chan,
  bba_out_if.source out_chan
);

  bba_cmd_t  cmd;
  bba_stat_t st;

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .st        (st),
    .cmd       (cmd)
  );

  bba_dp #(
    .NUM_BITS (NUM_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .st                   (st),
    .in_opcode            (in_chan.opcode),
    .in_bit_index         (in_chan.bit_index),
    .in_byte_index        (in_chan.byte_index),
    .in_load_value        (in_chan.load_value),
    .in_write_back        (in_chan.write_back),
    .out_bit_value        (out_chan.bit_value),
    .out_alloc_index      (out_chan.alloc_index),
    .out_alloc_ok         (out_chan.alloc_ok),
    .out_first_free_index (out_chan.first_free_index),
    .out_first_free_valid (out_chan.first_free_valid),
    .out_free_count       (out_chan.free_count),
    .out_dump_valid       (out_chan.dump_valid),
    .out_dump_byte_index  (out_chan.dump_byte_index),
    .out_dump_byte_value  (out_chan.dump_byte_value)
  );

endmodule

`default_nettype wire

### sim/tb_bitmap_block_allocator.sv
// testbench of the bitmap block allocator: directed and random operations against a bitmap mirror
`timescale 1ns / 1ps

localparam int MAP_BYTES = bba_pkg::NUM_BITS_DEF / 8;

typedef struct {
  logic [bba_pkg::OPC_W-1:0]  opcode;
  logic [bba_pkg::BIT_W-1:0]  bit_index;
  logic [bba_pkg::BYTE_W-1:0] byte_index;
  logic [bba_pkg::VAL_W-1:0]  load_value;
  logic                       write_back;
} bba_request_t;

typedef struct {
  logic                       bit_value;
  logic [bba_pkg::BIT_W-1:0]  alloc_index;
  logic                       alloc_ok;
  logic [bba_pkg::BIT_W-1:0]  first_free_index;
  logic                       first_free_valid;
  logic [bba_pkg::CNT_W-1:0]  free_count;
  logic                       dump_valid;
  logic [bba_pkg::BYTE_W-1:0] dump_byte_index;
  logic [bba_pkg::VAL_W-1:0]  dump_byte_value;
} bba_status_t;

class bitmap_mirror;
  logic [7:0]  map_bytes [MAP_BYTES];
  int          head_free;
  bit          head_free_ok;
  int          free_bits;
  bba_status_t pending_status [$];
  int          errors;

  function new();
    foreach (map_bytes[i]) map_bytes[i] = '0;
    head_free    = 0;
    head_free_ok = 1'b0;
    free_bits    = 0;
    errors       = 0;
  endfunction

  // forward walk for the lowest clear bit, starting at a byte
  function void seek_free(int start_byte);
    head_free    = 0;
    head_free_ok = 1'b0;
    for (int i = start_byte; i < MAP_BYTES; i++) begin
      if (map_bytes[i] != 8'hFF) begin
        for (int k = 7; k >= 0; k--) begin
          if (!map_bytes[i][k]) head_free = i * 8 + k;
        end
        head_free_ok = 1'b1;
        return;
      end
    end
  endfunction

  function int flip_bit(int idx, bit used);
    int         pos;
    logic [7:0] old_val;
    pos = idx / 8;
    old_val = map_bytes[pos];
    map_bytes[pos][idx % 8] = used;
    // count only moves on a real change and saturates at both ends
    if (map_bytes[pos] != old_val) begin
      if (used && free_bits > 0) free_bits--;
      else if (!used && free_bits < bba_pkg::NUM_BITS_DEF) free_bits++;
    end
    if (used) begin
      if (head_free_ok && idx == head_free) seek_free(pos);
    end else if (!head_free_ok || idx < head_free) begin
      head_free    = idx;
      head_free_ok = 1'b1;
    end
    return pos;
  endfunction

  function void note_request(bba_request_t rq);
    bba_status_t st;
    int          idx;
    int          pos;
    st = '{default: '0};
    idx = int'(rq.bit_index);
    case (rq.opcode)
      bba_pkg::OP_LOAD: begin
        if (rq.byte_index < MAP_BYTES) map_bytes[rq.byte_index] = rq.load_value;
      end
      bba_pkg::OP_RESCAN: begin
        free_bits = 0;
        foreach (map_bytes[i]) free_bits += $countones(~map_bytes[i]);
        seek_free(0);
      end
      bba_pkg::OP_READ: begin
        if (idx < bba_pkg::NUM_BITS_DEF) st.bit_value = map_bytes[idx / 8][idx % 8];
      end
      bba_pkg::OP_SET, bba_pkg::OP_CLEAR: begin
        if (idx < bba_pkg::NUM_BITS_DEF) begin
          pos = flip_bit(idx, rq.opcode == bba_pkg::OP_SET);
          if (rq.write_back) begin
            st.dump_valid      = 1'b1;
            st.dump_byte_index = pos[bba_pkg::BYTE_W-1:0];
            st.dump_byte_value = map_bytes[pos];
          end
        end
      end
      bba_pkg::OP_ALLOC: begin
        if (head_free_ok) begin
          st.alloc_index     = head_free[bba_pkg::BIT_W-1:0];
          st.alloc_ok        = 1'b1;
          pos = flip_bit(head_free, 1'b1);
          // allocate reports its byte regardless of write_back
          st.dump_valid      = 1'b1;
          st.dump_byte_index = pos[bba_pkg::BYTE_W-1:0];
          st.dump_byte_value = map_bytes[pos];
        end
      end
      default: ;
    endcase
    st.first_free_index = head_free_ok ? head_free[bba_pkg::BIT_W-1:0] : '0;
    st.first_free_valid = head_free_ok;
    st.free_count       = free_bits[bba_pkg::CNT_W-1:0];
    pending_status.push_back(st);
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  function void check_result(bba_status_t got);
    bba_status_t want;
    if (pending_status.size() == 0) begin
      $error("result transfer with no operation outstanding");
      errors++;
      return;
    end
    want = pending_status.pop_front();
    compare_field("bit_value", 32'(want.bit_value), 32'(got.bit_value));
    compare_field("alloc_index", 32'(want.alloc_index), 32'(got.alloc_index));
    compare_field("alloc_ok", 32'(want.alloc_ok), 32'(got.alloc_ok));
    compare_field("first_free_index", 32'(want.first_free_index),
                  32'(got.first_free_index));
    compare_field("first_free_valid", 32'(want.first_free_valid),
                  32'(got.first_free_valid));
    compare_field("free_count", 32'(want.free_count), 32'(got.free_count));
    compare_field("dump_valid", 32'(want.dump_valid), 32'(got.dump_valid));
    compare_field("dump_byte_index", 32'(want.dump_byte_index), 32'(got.dump_byte_index));
    compare_field("dump_byte_value", 32'(want.dump_byte_value), 32'(got.dump_byte_value));
  endfunction
endclass

module tb_bitmap_block_allocator;
  import bba_pkg::*;

  localparam int CYCLE_LIMIT      = 5_000_000;
  localparam int DRAIN_CYCLES     = MAP_BYTES + 16;
  localparam int RANDOM_PER_PHASE = 130;
  localparam logic [OPC_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OPC_W-1:0] OP_SPARE7 = 3'd7;

  logic clk;
  logic rst_n;

  bba_in_if  in_ch ();
  bba_out_if out_ch ();

  bitmap_block_allocator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  bitmap_mirror mirror;
  bba_status_t  seen;
  int           snd_idle_pct;
  int           rcv_idle_pct;
  int           cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      seen.bit_value        = out_ch.bit_value;
      seen.alloc_index      = out_ch.alloc_index;
      seen.alloc_ok         = out_ch.alloc_ok;
      seen.first_free_index = out_ch.first_free_index;
      seen.first_free_valid = out_ch.first_free_valid;
      seen.free_count       = out_ch.free_count;
      seen.dump_valid       = out_ch.dump_valid;
      seen.dump_byte_index  = out_ch.dump_byte_index;
      seen.dump_byte_value  = out_ch.dump_byte_value;
      mirror.check_result(seen);
    end
    out_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  task automatic send_op(input logic [OPC_W-1:0] op, input logic [BIT_W-1:0] bidx,
                         input logic [BYTE_W-1:0] byidx, input logic [VAL_W-1:0] val,
                         input logic wb);
    bba_request_t rq;
    if ($urandom_range(0, 99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < snd_idle_pct) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.bit_index  <= bidx;
    in_ch.byte_index <= byidx;
    in_ch.load_value <= val;
    in_ch.write_back <= wb;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    rq.opcode     = op;
    rq.bit_index  = bidx;
    rq.byte_index = byidx;
    rq.load_value = val;
    rq.write_back = wb;
    mirror.note_request(rq);
  endtask

  // density 0 mostly free, 1 mostly used, else anything
  function automatic logic [VAL_W-1:0] byte_value(int density);
    int r;
    r = $urandom_range(0, 9);
    case (density)
      0:       return (r < 6) ? 8'h00 : VAL_W'($urandom_range(0, 255));
      1:       return (r < 5) ? 8'hFF :
                      (r < 9) ? ~(8'h01 << $urandom_range(0, 7)) :
                                VAL_W'($urandom_range(0, 255));
      default: return VAL_W'($urandom_range(0, 255));
    endcase
  endfunction

  // bits around the first free one: just above it and the used run below it
  function automatic logic [BIT_W-1:0] pick_bit();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return BIT_W'(mirror.head_free + $urandom_range(0, 7));
    if (r < 6) return BIT_W'(mirror.head_free - $urandom_range(0, 31));
    return BIT_W'($urandom_range(0, NUM_BITS_DEF - 1));
  endfunction

  function automatic logic [BYTE_W-1:0] pick_byte();
    if ($urandom_range(0, 1) == 0) return BYTE_W'(mirror.head_free / 8 + $urandom_range(0, 3));
    return BYTE_W'($urandom_range(0, MAP_BYTES - 1));
  endfunction

  task automatic fill_bitmap(input bit all_free);
    for (int i = 0; i < MAP_BYTES; i++) begin
      send_op(OP_LOAD, pick_bit(), BYTE_W'(i), all_free ? 8'h00 : byte_value(1),
              1'($urandom_range(0, 1)));
    end
  endtask

  task automatic run_directed();
    send_op(OP_READ, 12'd0, 9'd0, 8'h00, 1'b0);
    send_op(OP_READ, 12'd4095, 9'd511, 8'hFF, 1'b1);
    // nothing known free before any rescan
    send_op(OP_ALLOC, 12'd0, 9'd0, 8'h00, 1'b1);
    send_op(OP_LOAD, 12'd0, 9'd511, 8'h7F, 1'b0);
    send_op(OP_CLEAR, 12'd4095, 9'd0, 8'h00, 1'b0);
    // last bit taken, search runs off the end, then the map reads as full
    send_op(OP_ALLOC, 12'd0, 9'd0, 8'h00, 1'b0);
    send_op(OP_ALLOC, 12'd4095, 9'd511, 8'hFF, 1'b0);
    send_op(OP_LOAD, 12'd0, 9'd0, 8'h00, 1'b0);
    // count is already zero and must stay there
    send_op(OP_SET, 12'd5, 9'd0, 8'h00, 1'b1);
    send_op(OP_CLEAR, 12'd2, 9'd0, 8'h00, 1'b1);
    send_op(OP_CLEAR, 12'd4, 9'd0, 8'h00, 1'b0);
    // marking the first free bit used restarts the search in its byte
    send_op(OP_SET, 12'd2, 9'd0, 8'h00, 1'b0);
    send_op(OP_READ, 12'd5, 9'd0, 8'h00, 1'b0);
    send_op(OP_READ, 12'd0, 9'd0, 8'h00, 1'b0);
    send_op(OP_SPARE6, 12'd4095, 9'd511, 8'hFF, 1'b1);
    send_op(OP_SPARE7, 12'd0, 9'd0, 8'h00, 1'b0);
    send_op(OP_RESCAN, 12'd0, 9'd0, 8'h00, 1'b0);
    send_op(OP_ALLOC, 12'd0, 9'd0, 8'h00, 1'b0);
    send_op(OP_SET, 12'd4095, 9'd0, 8'h00, 1'b1);
    send_op(OP_CLEAR, 12'd4094, 9'd0, 8'h00, 1'b1);
  endtask

  task automatic random_run(input int target);
    int               done;
    int               density;
    int               r;
    logic [OPC_W-1:0] op;
    done = 0;
    while (done < target) begin
      density = $urandom_range(0, 2);
      repeat ($urandom_range(0, 10)) begin
        send_op(OP_LOAD, pick_bit(), pick_byte(), byte_value(density),
                1'($urandom_range(0, 1)));
        done++;
      end
      if ($urandom_range(0, 3) == 0) begin
        send_op(OP_RESCAN, pick_bit(), pick_byte(), byte_value(2), 1'($urandom_range(0, 1)));
        done++;
      end
      repeat ($urandom_range(10, 40)) begin
        r = $urandom_range(0, 99);
        if (r < 30)      op = OP_ALLOC;
        else if (r < 48) op = OP_SET;
        else if (r < 66) op = OP_CLEAR;
        else if (r < 80) op = OP_READ;
        else if (r < 90) op = OP_LOAD;
        else if (r < 92) op = OP_RESCAN;
        else             op = r[0] ? OP_SPARE7 : OP_SPARE6;
        send_op(op, pick_bit(), pick_byte(), byte_value(density), 1'($urandom_range(0, 1)));
        if (op != OP_SPARE6 && op != OP_SPARE7) done++;
      end
    end
  endtask

  initial begin
    mirror = new();
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = OP_LOAD;
    in_ch.bit_index  = '0;
    in_ch.byte_index = '0;
    in_ch.load_value = '0;
    in_ch.write_back = 1'b0;
    snd_idle_pct     = 26;
    rcv_idle_pct     = 72;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // every byte is loaded before anything reads or walks the map
    fill_bitmap(1'b1);
    run_directed();
    // the directed run only touched the first and last bytes
    send_op(OP_LOAD, 12'd0, 9'd0, 8'h00, 1'b0);
    send_op(OP_LOAD, 12'd0, 9'd511, 8'h00, 1'b0);
    send_op(OP_RESCAN, 12'd0, 9'd0, 8'h00, 1'b0);
    // stale count after the load pushes the free count against its upper bound
    send_op(OP_LOAD, 12'd0, 9'd7, 8'hFF, 1'b0);
    send_op(OP_CLEAR, 12'd56, 9'd0, 8'h00, 1'b1);
    send_op(OP_ALLOC, 12'd0, 9'd0, 8'h00, 1'b0);
    random_run(RANDOM_PER_PHASE);

    snd_idle_pct = 72;
    rcv_idle_pct = 26;
    random_run(RANDOM_PER_PHASE);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    random_run(RANDOM_PER_PHASE);

    in_ch.valid <= 1'b0;
    while (mirror.pending_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mirror.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/bba_pkg.sv
hw/rtl/bba_if.sv
hw/rtl/bba_ram.sv
hw/rtl/bba_ctrl.sv
hw/rtl/bba_dp.sv
hw/rtl/bitmap_block_allocator.sv
sim/tb_bitmap_block_allocator.sv
